FILE: hw/rtl/fbms_pkg.sv
// ----------------------------------------------------------------------------
// fbms_pkg
// Shared types, constants and codes of the frame blur and motion suppressor.
// ----------------------------------------------------------------------------
package fbms_pkg;

   // default line buffer depth and frame height limit
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   // register port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [11:0] RST_FRAME_WIDTH    = 12'd640;
   localparam logic [11:0] RST_FRAME_HEIGHT   = 12'd480;
   localparam logic [23:0] RST_BLUR_THRESHOLD = 24'd1600;
   localparam logic [14:0] RST_TURN_THRESHOLD = 15'd128;
   localparam logic        RST_PUBLISH_STATUS = 1'b1;

   // gray conversion weights, q14
   localparam logic [21:0] GRAY_W_BLUE  = 22'd1868;
   localparam logic [21:0] GRAY_W_GREEN = 22'd9617;
   localparam logic [21:0] GRAY_W_RED   = 22'd4899;
   localparam logic [21:0] GRAY_ROUND   = 22'd8192;

   // register indexes
   typedef enum logic [2:0] {
      REG_FRAME_WIDTH    = 3'd0,
      REG_FRAME_HEIGHT   = 3'd1,
      REG_BLUR_THRESHOLD = 3'd2,
      REG_TURN_THRESHOLD = 3'd3,
      REG_PUBLISH_STATUS = 3'd4
   } reg_index_type;

   // request operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_RATE  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
      logic signed [15:0] angular_rate;
   } req_type;

   typedef struct packed {
      logic blurred;
      logic turning;
      logic blur_hold;
      logic turn_hold;
      logic forward_frame;
      logic status_valid;
   } rsp_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [23:0] blur_threshold;
      logic [14:0] turn_threshold;
      logic        publish_status;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIX,
      ST_LAP,
      ST_ACC,
      ST_TRD,
      ST_TLAP,
      ST_TACC,
      ST_SIZE,
      ST_MGO,
      ST_MWAIT,
      ST_CMP,
      ST_OUT
   } ctrl_state_type;

   // products formed by the shared multiplier at frame end
   typedef enum logic [1:0] {
      MUL_NSQ,
      MUL_PROD,
      MUL_SUMSQ,
      MUL_LIMIT
   } mul_sel_type;

   typedef struct packed {
      logic        pix_load;
      logic        rate_load;
      logic        lap_en;
      logic        tail_mode;
      logic        acc_en;
      logic        tail_first;
      logic        tail_next;
      logic        size_en;
      logic        mul_start;
      logic        mul_capture;
      mul_sel_type mul_sel;
      logic        cmp_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic row_zero;
      logic frame_end;
      logic tail_last;
      logic mul_busy;
      logic out_free;
   } status_type;

endpackage

FILE: hw/rtl/frame_blur_motion_suppressor_unit.sv
// ----------------------------------------------------------------------------
// frame_blur_motion_suppressor_unit
// Laplacian variance blur test and turn-rate test on a raster pixel stream.
// ----------------------------------------------------------------------------
// A rate request only loads the held rate and leaves the block idle. A pixel
// passes through capture, buffer read, Laplacian and accumulate steps; a pixel
// of the first row skips the accumulate step. The last pixel of a frame adds
// a last-row sweep and four shift-add products, b operand BW = 34 bits by default.
// The result sits in an output register; new requests are taken meanwhile.
// Reset is synchronous: registers return to defaults, counters and sums clear.
// ----------------------------------------------------------------------------
module frame_blur_motion_suppressor_unit #(
   parameter int MAX_WIDTH  = fbms_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fbms_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fbms_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fbms_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fbms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fbms_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fbms_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   fbms_pkg::cfg_type       cfg_ff;
   fbms_pkg::reg_index_type reg_idx;
   logic                    csr_wr;
   logic                    cfg_restart;

   assign pready  = 1'b1;
   assign reg_idx = fbms_pkg::reg_index_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= fbms_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height   <= fbms_pkg::RST_FRAME_HEIGHT;
         cfg_ff.blur_threshold <= fbms_pkg::RST_BLUR_THRESHOLD;
         cfg_ff.turn_threshold <= fbms_pkg::RST_TURN_THRESHOLD;
         cfg_ff.publish_status <= fbms_pkg::RST_PUBLISH_STATUS;
      end else if (csr_wr) begin
         case (reg_idx)
            fbms_pkg::REG_FRAME_WIDTH:    cfg_ff.frame_width    <= pwdata[11:0];
            fbms_pkg::REG_FRAME_HEIGHT:   cfg_ff.frame_height   <= pwdata[11:0];
            fbms_pkg::REG_BLUR_THRESHOLD: cfg_ff.blur_threshold <= pwdata[23:0];
            fbms_pkg::REG_TURN_THRESHOLD: cfg_ff.turn_threshold <= pwdata[14:0];
            fbms_pkg::REG_PUBLISH_STATUS: cfg_ff.publish_status <= pwdata[0];
            default:                      cfg_ff <= cfg_ff;
         endcase
      end
   end

   // a size change starts a new frame
   assign cfg_restart = csr_wr && ((reg_idx == fbms_pkg::REG_FRAME_WIDTH) ||
                                   (reg_idx == fbms_pkg::REG_FRAME_HEIGHT));

   // register readback
   always_comb begin
      case (reg_idx)
         fbms_pkg::REG_FRAME_WIDTH:    prdata = 32'(cfg_ff.frame_width);
         fbms_pkg::REG_FRAME_HEIGHT:   prdata = 32'(cfg_ff.frame_height);
         fbms_pkg::REG_BLUR_THRESHOLD: prdata = 32'(cfg_ff.blur_threshold);
         fbms_pkg::REG_TURN_THRESHOLD: prdata = 32'(cfg_ff.turn_threshold);
         fbms_pkg::REG_PUBLISH_STATUS: prdata = 32'(cfg_ff.publish_status);
         default:                      prdata = '0;
      endcase
   end

   fbms_pkg::cmd_type    cmd;
   fbms_pkg::status_type status;

   fbms_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_data.operation),
      .req_stall    (req_stall),
      .status       (status),
      .cmd          (cmd)
   );

   fbms_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg_ff),
      .cfg_restart(cfg_restart),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/fbms_mul.sv
// ----------------------------------------------------------------------------
// fbms_mul
// Shift-add multiplier, one bit of the b operand per cycle.
// ----------------------------------------------------------------------------
module fbms_mul #(
   parameter int A_W = 46,
   parameter int B_W = 34
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               busy,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W = A_W + B_W;
   localparam int C_W = $clog2(B_W + 1);

   logic [P_W-1:0] acc_ff;
   logic [P_W-1:0] a_sh_ff;
   logic [B_W-1:0] b_sh_ff;
   logic [C_W-1:0] cnt_ff;
   logic           busy_ff;

   // control: count down one step per operand bit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= C_W'(B_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - C_W'(1);
         if (cnt_ff == C_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // partial product accumulation
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= P_W'(a);
         b_sh_ff <= b;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_ff <= acc_ff + a_sh_ff;
         end
         a_sh_ff <= {a_sh_ff[P_W-2:0], 1'b0};
         b_sh_ff <= {1'b0, b_sh_ff[B_W-1:1]};
      end
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

FILE: hw/rtl/fbms_datapath.sv
// ----------------------------------------------------------------------------
// fbms_datapath
// Gray conversion, row buffers, Laplacian, accumulators, frame-end compare
// and the result register.
// ----------------------------------------------------------------------------
module fbms_datapath #(
   parameter int MAX_WIDTH  = fbms_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fbms_pkg::DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fbms_pkg::cmd_type    cmd,
   output fbms_pkg::status_type status,
   input  fbms_pkg::cfg_type    cfg,
   input  logic                 cfg_restart,
   input  fbms_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fbms_pkg::rsp_type    rsp_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PB = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int NW = PB + 1;
   localparam int SW = PB + 12;
   localparam int QW = PB + 20;
   localparam int AW = (QW > 2 * NW) ? QW : 2 * NW;
   localparam int BW = (SW > 24) ? SW : 24;
   localparam int PW = AW + BW;

   // frame size saturated to the supported range
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [CW-1:0] wm1;
   logic [RW-1:0] hm1;

   always_comb begin
      if (cfg.frame_width < 12'd3) begin
         w_eff = WW'(3);
      end else if ({20'd0, cfg.frame_width} > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.frame_width);
      end
      if (cfg.frame_height < 12'd3) begin
         h_eff = HW'(3);
      end else if ({20'd0, cfg.frame_height} > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(cfg.frame_height);
      end
      wm1 = CW'(w_eff - WW'(1));
      hm1 = RW'(h_eff - HW'(1));
   end

   // request capture and gray conversion
   logic [7:0]         blue_ff, green_ff, red_ff;
   logic [7:0]         gray_ff;
   logic [21:0]        gray_sum;
   logic signed [15:0] held_rate_ff;

   assign gray_sum = fbms_pkg::GRAY_W_BLUE * 22'(blue_ff);

   logic [21:0] gray_full;
   assign gray_full = gray_sum + fbms_pkg::GRAY_W_GREEN * 22'(green_ff)
                      + fbms_pkg::GRAY_W_RED * 22'(red_ff) + fbms_pkg::GRAY_ROUND;

   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         blue_ff  <= req_data.blue;
         green_ff <= req_data.green;
         red_ff   <= req_data.red;
      end
      gray_ff <= gray_full[21:14];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_rate_ff <= '0;
      end else if (cmd.rate_load) begin
         held_rate_ff <= req_data.angular_rate;
      end
   end

   // frame position and buffer address
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] addr_ff;
   logic [CW-1:0] addr_nx;
   logic          frame_end_ff;
   logic          pix_lap;
   logic          at_first, at_last;

   assign addr_nx  = addr_ff + CW'(1);
   assign at_first = (addr_ff == '0);
   assign at_last  = (addr_ff == wm1);
   assign pix_lap  = cmd.lap_en && !cmd.tail_mode;

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         col_ff       <= '0;
         row_ff       <= '0;
         frame_end_ff <= 1'b0;
      end else if (pix_lap) begin
         frame_end_ff <= at_last && (row_ff == hm1);
         if (at_last) begin
            col_ff <= '0;
            row_ff <= (row_ff == hm1) ? '0 : row_ff + RW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         addr_ff <= col_ff;
      end else if (cmd.tail_first) begin
         addr_ff <= '0;
      end else if (cmd.tail_next) begin
         addr_ff <= addr_nx;
      end
   end

   // row buffers: middle row with two read ports, upper row with one
   logic [7:0] mid_mem [MAX_WIDTH];
   logic [7:0] up_mem  [MAX_WIDTH];
   logic [7:0] mid_a_q, mid_b_q, up_q;
   logic       mid_we, up_we;

   assign mid_we = pix_lap;
   assign up_we  = pix_lap && (row_ff != '0);

   always_ff @(posedge clock) begin
      if (mid_we) begin
         mid_mem[addr_ff] <= gray_ff;
      end
      mid_a_q <= mid_mem[addr_ff];
      mid_b_q <= mid_mem[addr_nx];
   end

   always_ff @(posedge clock) begin
      if (up_we) begin
         up_mem[addr_ff] <= mid_a_q;
      end
      up_q <= up_mem[addr_ff];
   end

   // laplacian of the center pixel
   logic [7:0]         lap_a, lap_b, lap_left, lap_right;
   logic [11:0]        lap_pos, lap_neg, lap_full;
   logic signed [10:0] lap_ff;
   logic [7:0]         left_ff;

   always_comb begin
      if (cmd.tail_mode) begin
         lap_a = up_q;
         lap_b = up_q;
      end else begin
         lap_a = (row_ff == RW'(1)) ? gray_ff : up_q;
         lap_b = gray_ff;
      end
      lap_left  = at_first ? mid_b_q : left_ff;
      lap_right = at_last ? left_ff : mid_b_q;
      lap_pos   = 12'(lap_a) + 12'(lap_b) + 12'(lap_left) + 12'(lap_right);
      lap_neg   = {2'b00, mid_a_q, 2'b00};
      lap_full  = lap_pos - lap_neg;
   end

   // accumulators
   logic signed [SW-1:0] sum_ff;
   logic [QW-1:0]        sq_ff;
   logic signed [21:0]   lap_sq;

   assign lap_sq = lap_ff * lap_ff;

   always_ff @(posedge clock) begin
      if (cmd.lap_en) begin
         lap_ff <= $signed(lap_full[10:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart || cmd.out_load) begin
         sum_ff  <= '0;
         sq_ff   <= '0;
         left_ff <= '0;
      end else begin
         if (cmd.acc_en) begin
            sum_ff <= sum_ff + SW'(lap_ff);
            sq_ff  <= sq_ff + QW'($unsigned(lap_sq));
         end
         if (cmd.tail_mode || up_we) begin
            left_ff <= mid_a_q;
         end
      end
   end

   // frame-end products through the shared multiplier
   logic [NW-1:0]   n_ff;
   logic [SW-1:0]   mag_ff;
   logic [2*NW-1:0] nsq_ff;
   logic [PW-1:0]   p1_ff, diff_ff, rhs_ff;
   logic [AW-1:0]   mul_a;
   logic [BW-1:0]   mul_b;
   logic [PW-1:0]   mul_p;
   logic            mul_busy;

   always_comb begin
      case (cmd.mul_sel)
         fbms_pkg::MUL_NSQ: begin
            mul_a = AW'(n_ff);
            mul_b = BW'(n_ff);
         end
         fbms_pkg::MUL_PROD: begin
            mul_a = AW'(sq_ff);
            mul_b = BW'(n_ff);
         end
         fbms_pkg::MUL_SUMSQ: begin
            mul_a = AW'(mag_ff);
            mul_b = BW'(mag_ff);
         end
         fbms_pkg::MUL_LIMIT: begin
            mul_a = AW'(nsq_ff);
            mul_b = BW'(cfg.blur_threshold);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   fbms_mul #(
      .A_W(AW),
      .B_W(BW)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .busy   (mul_busy),
      .product(mul_p)
   );

   always_ff @(posedge clock) begin
      if (cmd.size_en) begin
         n_ff   <= NW'(w_eff) * NW'(h_eff);
         mag_ff <= sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      end
      if (cmd.mul_capture) begin
         case (cmd.mul_sel)
            fbms_pkg::MUL_NSQ:   nsq_ff  <= mul_p[2*NW-1:0];
            fbms_pkg::MUL_PROD:  p1_ff   <= mul_p;
            fbms_pkg::MUL_SUMSQ: diff_ff <= p1_ff - mul_p;
            fbms_pkg::MUL_LIMIT: rhs_ff  <= mul_p;
            default:             rhs_ff  <= rhs_ff;
         endcase
      end
   end

   // flag decisions
   logic [16:0] rate_ext, rate_mag;
   logic        blurred_ff, turning_ff;

   assign rate_ext = {held_rate_ff[15], held_rate_ff};
   assign rate_mag = held_rate_ff[15] ? (17'd0 - rate_ext) : rate_ext;

   always_ff @(posedge clock) begin
      if (cmd.cmp_en) begin
         blurred_ff <= ({diff_ff, 4'b0000} < {4'b0000, rhs_ff});
         turning_ff <= (rate_mag > {2'b00, cfg.turn_threshold});
      end
   end

   // result register and prior-frame flags
   logic                prior_blurred_ff, prior_turning_ff;
   logic                rsp_valid_ff;
   fbms_pkg::rsp_type   rsp_data_ff;
   logic                bhold, thold;

   assign bhold = prior_blurred_ff && !blurred_ff;
   assign thold = prior_turning_ff && !turning_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         prior_blurred_ff <= 1'b0;
         prior_turning_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff     <= 1'b1;
         prior_blurred_ff <= blurred_ff;
         prior_turning_ff <= turning_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.blurred       <= blurred_ff;
         rsp_data_ff.turning       <= turning_ff;
         rsp_data_ff.blur_hold     <= bhold;
         rsp_data_ff.turn_hold     <= thold;
         rsp_data_ff.forward_frame <= !(blurred_ff || turning_ff || bhold || thold);
         rsp_data_ff.status_valid  <= cfg.publish_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to the controller
   assign status.row_zero  = (row_ff == '0);
   assign status.frame_end = frame_end_ff;
   assign status.tail_last = at_last;
   assign status.mul_busy  = mul_busy;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: hw/rtl/fbms_ctrl.sv
// ----------------------------------------------------------------------------
// fbms_ctrl
// Sequencer: pixel steps, last-row sweep, frame-end products and result.
// ----------------------------------------------------------------------------
module fbms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_stall,
   input  fbms_pkg::status_type status,
   output fbms_pkg::cmd_type    cmd
);

   fbms_pkg::ctrl_state_type state_ff, state_in;
   fbms_pkg::mul_sel_type    sel_ff, sel_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbms_pkg::ST_IDLE;
         sel_ff   <= fbms_pkg::MUL_NSQ;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.mul_sel = sel_ff;
      req_stall = 1'b1;
      case (state_ff)
         fbms_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == fbms_pkg::OP_RATE) begin
                  cmd.rate_load = 1'b1;
               end else begin
                  cmd.pix_load = 1'b1;
                  state_in     = fbms_pkg::ST_PIX;
               end
            end
         end
         fbms_pkg::ST_PIX: begin
            state_in = fbms_pkg::ST_LAP;
         end
         fbms_pkg::ST_LAP: begin
            cmd.lap_en = 1'b1;
            state_in   = status.row_zero ? fbms_pkg::ST_IDLE : fbms_pkg::ST_ACC;
         end
         fbms_pkg::ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (status.frame_end) begin
               cmd.tail_first = 1'b1;
               state_in       = fbms_pkg::ST_TRD;
            end else begin
               state_in = fbms_pkg::ST_IDLE;
            end
         end
         fbms_pkg::ST_TRD: begin
            state_in = fbms_pkg::ST_TLAP;
         end
         fbms_pkg::ST_TLAP: begin
            cmd.lap_en    = 1'b1;
            cmd.tail_mode = 1'b1;
            state_in      = fbms_pkg::ST_TACC;
         end
         fbms_pkg::ST_TACC: begin
            cmd.acc_en = 1'b1;
            if (status.tail_last) begin
               state_in = fbms_pkg::ST_SIZE;
            end else begin
               cmd.tail_next = 1'b1;
               state_in      = fbms_pkg::ST_TRD;
            end
         end
         fbms_pkg::ST_SIZE: begin
            cmd.size_en = 1'b1;
            sel_in      = fbms_pkg::MUL_NSQ;
            state_in    = fbms_pkg::ST_MGO;
         end
         fbms_pkg::ST_MGO: begin
            cmd.mul_start = 1'b1;
            state_in      = fbms_pkg::ST_MWAIT;
         end
         fbms_pkg::ST_MWAIT: begin
            if (!status.mul_busy) begin
               cmd.mul_capture = 1'b1;
               case (sel_ff)
                  fbms_pkg::MUL_NSQ:   sel_in = fbms_pkg::MUL_PROD;
                  fbms_pkg::MUL_PROD:  sel_in = fbms_pkg::MUL_SUMSQ;
                  fbms_pkg::MUL_SUMSQ: sel_in = fbms_pkg::MUL_LIMIT;
                  default:             sel_in = fbms_pkg::MUL_NSQ;
               endcase
               state_in = (sel_ff == fbms_pkg::MUL_LIMIT) ? fbms_pkg::ST_CMP
                                                           : fbms_pkg::ST_MGO;
            end
         end
         fbms_pkg::ST_CMP: begin
            cmd.cmp_en = 1'b1;
            state_in   = fbms_pkg::ST_OUT;
         end
         fbms_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = fbms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbms_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/fbms_checker.sv
// ----------------------------------------------------------------------------
// fbms_checker
// Port-level checks of the suppressor, bound to the top level.
// ----------------------------------------------------------------------------
module fbms_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input fbms_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fbms_pkg::rsp_type rsp_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // forward decision follows the four flags
   a_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.forward_frame == !(rsp_data.blurred || rsp_data.turning ||
                                                 rsp_data.blur_hold || rsp_data.turn_hold))
      else $error("forward_frame inconsistent with flags");

   // a hold bit only appears when its flag has dropped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.blurred && rsp_data.blur_hold) &&
                    !(rsp_data.turning && rsp_data.turn_hold))
      else $error("hold bit set with its flag");

   // a pixel request occupies the block for following cycles
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.operation == fbms_pkg::OP_PIXEL) |=> req_stall)
      else $error("pixel request not followed by stall");

endmodule

bind frame_blur_motion_suppressor_unit fbms_checker u_fbms_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
